>>> design/assert_macros.svh
// assertion macros shared by the rep counter rtl
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define AERC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("aerc assertion failed");

`define AERC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("aerc implication failed");

`define AERC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("aerc next-cycle check failed");

`else

`define AERC_ASSERT(lbl, clk, rstn, prop)

`define AERC_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define AERC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> design/aerc_pkg.sv
// types and constants of the accelerometer exercise rep counter
// no dependencies
`default_nettype none

package aerc_pkg;

  typedef struct packed {
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               button;
  } aerc_in_t;

  typedef struct packed {
    logic [1:0] posture;
    logic [2:0] exercise;
    logic [7:0] situp_reps;
    logic [7:0] squat_reps;
    logic [8:0] jack_halves;
    logic [7:0] pushup_reps;
    logic [3:0] leds;
    logic       all_done_flash;
  } aerc_out_t;

  typedef enum logic [1:0] {
    POS_UP   = 2'd0,
    POS_SIT  = 2'd1,
    POS_DOWN = 2'd2
  } posture_e;

  typedef enum logic [4:0] {
    EX_SITUP  = 5'b00001,
    EX_SQUAT  = 5'b00010,
    EX_JACK   = 5'b00100,
    EX_PUSHUP = 5'b01000,
    EX_DETECT = 5'b10000
  } ex_state_e;

  // exercise codes on the result beat
  localparam logic [2:0] EXC_SITUP  = 3'd0;
  localparam logic [2:0] EXC_SQUAT  = 3'd1;
  localparam logic [2:0] EXC_JACK   = 3'd2;
  localparam logic [2:0] EXC_PUSHUP = 3'd3;
  localparam logic [2:0] EXC_DETECT = 3'd4;

  // phase bit positions
  localparam int unsigned PH_SITUP  = 0;
  localparam int unsigned PH_SQUAT  = 1;
  localparam int unsigned PH_JACK   = 2;
  localparam int unsigned PH_PUSHUP = 3;

  // led bit positions
  localparam int unsigned LAMP_SITUP  = 0;
  localparam int unsigned LAMP_PUSHUP = 1;
  localparam int unsigned LAMP_SQUAT  = 2;
  localparam int unsigned LAMP_JACK   = 3;

  localparam longint G_COUNTS = 17694;

  localparam logic signed [15:0] Y_JACK_SWITCH = -16'sd30000;
  localparam logic signed [15:0] Y_SQUAT_LEVEL = -16'sd20000;
  localparam logic signed [15:0] Y_JACK_LOW    = -16'sd10000;
  localparam logic signed [15:0] Z_PUSH_ARM    = -16'sd12000;
  localparam logic signed [15:0] Z_PUSH_COUNT  = -16'sd15000;

  localparam logic [7:0] TARGET_RESET = 8'd15;
  localparam logic [8:0] JACK_RESET   = 9'd2;
  localparam logic [7:0] REP_MAX      = 8'hFF;
  localparam logic [8:0] JACK_MAX     = 9'h1FF;

endpackage

`default_nettype wire

>>> design/accel_exercise_rep_counter.sv
// top level of the accelerometer exercise rep counter
// depends on aerc_pkg, aerc_window, aerc_reps and assert_macros.svh
//
//   port group   dir  handshake                  payload
//   in           in   in_valid_i / in_stall_o    in_data_i   (aerc_in_t)
//   out          out  out_valid_o / out_stall_i  out_data_o  (aerc_out_t)
//   cfg          in   cfg_we_i                   cfg_wdata_i (rep_target)
//
// one beat per cycle while out_stall_i stays low; a beat is registered in the input register,
// is processed from there and lands in the result register when the result register advances
// window sum update, posture compare and counter update all happen in that same cycle
// a stalled result register holds the input register, which then stalls the input
// reset clears the z window, sum, posture, counters and leds, but jack halves start at 2; rep_target returns to 15
`default_nettype none
`include "assert_macros.svh"

module accel_exercise_rep_counter import aerc_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire aerc_in_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output aerc_out_t       out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  logic      in_valid_q;
  aerc_in_t  in_q;
  logic      out_valid_q;
  aerc_out_t out_q;
  aerc_out_t result;
  posture_e  posture;
  logic [7:0] target_q;
  logic      advance;
  logic      fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      target_q    <= TARGET_RESET;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= in_valid_q;
      if (cfg_we_i) target_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_q <= in_data_i;
    if (fire) out_q <= result;
  end

  aerc_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (fire),
    .accel_z_i (in_q.accel_z),
    .posture_o (posture)
  );

  aerc_reps u_reps (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (fire),
    .beat_i    (in_q),
    .posture_i (posture),
    .target_i  (target_q),
    .result_o  (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `AERC_ASSERT_IMP(a_stall_needs_beat, clk_i, rst_ni, in_stall_o, in_valid_q && out_valid_q)
  `AERC_ASSERT_IMP(a_flash_dark, clk_i, rst_ni, out_valid_q && out_q.all_done_flash, out_q.leds == 4'd0)
  `AERC_ASSERT_IMP(a_jack_floor, clk_i, rst_ni, out_valid_q, out_q.jack_halves >= JACK_RESET)
  `AERC_ASSERT_NEXT(a_fire_fills_out, clk_i, rst_ni, fire, out_valid_q)

endmodule

`default_nettype wire

>>> design/aerc_window.sv
// z sample shift line, running window sum and posture classification
// depends on aerc_pkg
`default_nettype none

module aerc_window import aerc_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic signed [15:0] accel_z_i,
  output posture_e                posture_o
);

  localparam int unsigned SUM_W = $clog2(WINDOW_LEN) + 16;
  localparam longint FULL_G = longint'(WINDOW_LEN) * G_COUNTS;

  // largest t with 2*t*t <= f*f, i.e. floor(f * cos45)
  function automatic longint cos45_floor(input longint f);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = f;
    for (int i = 0; i < 40; i++) begin
      mid = (lo + hi + 1) / 2;
      if (2 * mid * mid <= f * f) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

  localparam longint THR = cos45_floor(FULL_G);
  localparam logic signed [SUM_W-1:0] THR_POS  = SUM_W'(THR);
  localparam logic signed [SUM_W-1:0] THR_NEG  = SUM_W'(-THR);
  localparam logic signed [SUM_W-1:0] FULL_NEG = SUM_W'(-FULL_G);

  logic signed [15:0]      taps_q [WINDOW_LEN];
  logic signed [SUM_W-1:0] sum_q, sum_d;
  posture_e                posture_q, posture_d;

  assign sum_d = sum_q + SUM_W'(accel_z_i) - SUM_W'(taps_q[WINDOW_LEN-1]);

  // a sum equal to THR_POS or THR_NEG counts as sit; a sum below FULL_NEG holds the posture
  always_comb begin
    posture_d = posture_q;
    if (sum_d > THR_POS) begin
      posture_d = POS_UP;
    end else if (sum_d >= THR_NEG) begin
      posture_d = POS_SIT;
    end else if (sum_d >= FULL_NEG) begin
      posture_d = POS_DOWN;
    end
  end

  assign posture_o = posture_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        taps_q[i] <= '0;
      end
      sum_q     <= '0;
      posture_q <= POS_UP;
    end else if (en_i) begin
      taps_q[0] <= accel_z_i;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        taps_q[i] <= taps_q[i-1];
      end
      sum_q     <= sum_d;
      posture_q <= posture_d;
    end
  end

endmodule

`default_nettype wire

>>> design/aerc_reps.sv
// exercise selection, phase tracking, rep counters and led latch
// depends on aerc_pkg
`default_nettype none

module aerc_reps import aerc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire aerc_in_t  beat_i,
  input  wire posture_e  posture_i,
  input  wire logic [7:0] target_i,
  output aerc_out_t      result_o
);

  ex_state_e  ex_q, ex_d;
  logic [3:0] phase_q, phase_d;
  logic [7:0] situp_q, situp_d;
  logic [7:0] squat_q, squat_d;
  logic [7:0] pushup_q, pushup_d;
  logic [8:0] jack_q, jack_d;
  logic [3:0] led_q, led_d;
  logic [8:0] target2;
  logic       flash;
  logic [2:0] ex_code;

  assign target2 = {target_i, 1'b0};

  always_comb begin
    ex_d     = ex_q;
    phase_d  = phase_q;
    situp_d  = situp_q;
    squat_d  = squat_q;
    pushup_d = pushup_q;
    jack_d   = jack_q;
    led_d    = led_q;
    flash    = 1'b0;

    case (ex_q)
      EX_SITUP: begin
        if (!phase_d[PH_SITUP]) begin
          if (posture_i == POS_UP) phase_d[PH_SITUP] = 1'b1;
        end else if (posture_i == POS_SIT) begin
          phase_d[PH_SITUP] = 1'b0;
          situp_d = (situp_q == REP_MAX) ? situp_q : situp_q + 8'd1;
        end
        if (situp_d == target_i) led_d[LAMP_SITUP] = 1'b1;
      end
      EX_SQUAT: begin
        if (beat_i.accel_y <= Y_JACK_SWITCH) begin
          ex_d = EX_JACK;
          phase_d[PH_SQUAT] = 1'b0;
        end
        if (!phase_d[PH_SQUAT]) begin
          if (beat_i.accel_y < Y_SQUAT_LEVEL) phase_d[PH_SQUAT] = 1'b1;
        end else if (beat_i.accel_y > Y_SQUAT_LEVEL) begin
          phase_d[PH_SQUAT] = 1'b0;
          squat_d = (squat_q == REP_MAX) ? squat_q : squat_q + 8'd1;
        end
        if (squat_d == target_i) led_d[LAMP_SQUAT] = 1'b1;
      end
      EX_JACK: begin
        if (!phase_d[PH_JACK]) begin
          if (beat_i.accel_y > 16'sd0) phase_d[PH_JACK] = 1'b1;
        end else if (beat_i.accel_y < Y_JACK_LOW) begin
          phase_d[PH_JACK] = 1'b0;
          jack_d = (jack_q == JACK_MAX) ? jack_q : jack_q + 9'd1;
        end
        if (jack_d == target2) led_d[LAMP_JACK] = 1'b1;
      end
      EX_PUSHUP: begin
        if (!phase_d[PH_PUSHUP]) begin
          if (beat_i.accel_z > Z_PUSH_ARM) phase_d[PH_PUSHUP] = 1'b1;
        end else if (beat_i.accel_z <= Z_PUSH_COUNT) begin
          phase_d[PH_PUSHUP] = 1'b0;
          pushup_d = (pushup_q == REP_MAX) ? pushup_q : pushup_q + 8'd1;
        end
        if (pushup_d == target_i) led_d[LAMP_PUSHUP] = 1'b1;
      end
      default: begin
      end
    endcase

    if (beat_i.button) begin
      case (posture_i)
        POS_UP:   ex_d = EX_SITUP;
        POS_DOWN: ex_d = EX_PUSHUP;
        default:  ex_d = EX_SQUAT;
      endcase
    end

    if (situp_d >= target_i && squat_d >= target_i &&
        jack_d >= target2 && pushup_d >= target_i) begin
      led_d = '0;
      flash = 1'b1;
    end
  end

  always_comb begin
    case (ex_d)
      EX_SITUP:  ex_code = EXC_SITUP;
      EX_SQUAT:  ex_code = EXC_SQUAT;
      EX_JACK:   ex_code = EXC_JACK;
      EX_PUSHUP: ex_code = EXC_PUSHUP;
      default:   ex_code = EXC_DETECT;
    endcase
  end

  always_comb begin
    result_o.posture        = posture_i;
    result_o.exercise       = ex_code;
    result_o.situp_reps     = situp_d;
    result_o.squat_reps     = squat_d;
    result_o.jack_halves    = jack_d;
    result_o.pushup_reps    = pushup_d;
    result_o.leds           = led_d;
    result_o.all_done_flash = flash;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_q     <= EX_DETECT;
      phase_q  <= '0;
      situp_q  <= '0;
      squat_q  <= '0;
      pushup_q <= '0;
      jack_q   <= JACK_RESET;
      led_q    <= '0;
    end else if (en_i) begin
      ex_q     <= ex_d;
      phase_q  <= phase_d;
      situp_q  <= situp_d;
      squat_q  <= squat_d;
      pushup_q <= pushup_d;
      jack_q   <= jack_d;
      led_q    <= led_d;
    end
  end

endmodule

`default_nettype wire
